>>> sv/plfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plfc_pkg
// Shared widths, command codes and structs of the PWM light fade controller.
// ----------------------------------------------------------------------------
package plfc_pkg;

    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 8;
    localparam int STEP_W  = 8;
    localparam int CMD_W   = 2;
    localparam int CNT_W   = $clog2(TIME_W);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = '0;

    localparam logic [STEP_W-1:0] STEP_MS_RESET     = STEP_W'(3);
    localparam logic              ACTIVE_HIGH_RESET = 1'b1;

    // register index = paddr[2]
    localparam logic REG_STEP_MS     = 1'b0;
    localparam logic REG_ACTIVE_HIGH = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_TOGGLE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [STEP_W-1:0] step_ms;
        logic              active_high;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [STEP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

>>> sv/plfc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plfc_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface plfc_in_if
    import plfc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic               on_request;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, output cmd, output on_request, output now_ms,
                    input ready);
    modport sink   (input valid, input cmd, input on_request, input now_ms,
                    output ready);
endinterface

interface plfc_out_if
    import plfc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               level_written;
    logic               light_is_on;
    logic               fading;
    logic               needs_power;

    modport source (output valid, output level, output level_written,
                    output light_is_on, output fading, output needs_power,
                    input ready);
    modport sink   (input valid, input level, input level_written,
                    input light_is_on, input fading, input needs_power,
                    output ready);
endinterface
`default_nettype wire

>>> sv/pwm_light_fade_controller.sv
`default_nettype none
// A tick that takes a brightness step goes from accept through the divider
//   iterations and done to the load of the result word; every other word goes
//   straight to the load. One word at a time: the next is taken once the result
//   is loaded, so stepping ticks are also held while the divider runs.
// Reset (rst_n, async, active low): level 0, pin low, no fade, timestamp 0,
//   step_ms 3, active_high 1; output register empty.
// ----------------------------------------------------------------------------
// pwm_light_fade_controller
// Fade sequencer for a PWM light: set (on a pin change) and toggle arm a fade,
// ticks advance the level by elapsed/step_ms using a shared iterative divider.
// ----------------------------------------------------------------------------
module pwm_light_fade_controller
    import plfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    plfc_in_if.sink                    in_ch,
    plfc_out_if.source                 out_ch
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               level_written;
        logic               light_is_on;
        logic               fading;
        logic               needs_power;
    } result_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t             state_reg,   state_next;
    logic [LEVEL_W-1:0] bright_reg,  bright_next;
    logic               target_reg,  target_next;
    logic               fade_reg,    fade_next;
    logic               pending_reg, pending_next;
    logic [TIME_W-1:0]  last_reg,    last_next;
    logic [TIME_W-1:0]  now_reg,     now_next;
    logic               wrote_reg,   wrote_next;
    logic               ovalid_reg,  ovalid_next;
    result_t            res_reg,     res_next;

    logic               accept;
    logic [STEP_W-1:0]  period;
    logic [TIME_W-1:0]  elapsed;
    logic [LEVEL_W-1:0] qsat;
    logic [LEVEL_W-1:0] room;
    logic [LEVEL_W-1:0] delta;
    logic               pin;
    logic               light_on;
    logic               out_free;

    // ------------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------------
    plfc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------------
    // Shared divider: elapsed / period
    // ------------------------------------------------------------------------
    plfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // A zero period acts as one millisecond.
    assign period  = (cfg.step_ms == '0) ? STEP_W'(1) : cfg.step_ms;
    assign elapsed = in_ch.now_ms - last_reg;

    // Pin level requested by a set, after polarity.
    assign pin = cfg.active_high ? in_ch.on_request : ~in_ch.on_request;

    // Saturate the quotient at the level range, then clamp at the limit.
    assign qsat  = (|div_rsp.quotient[TIME_W-1:LEVEL_W]) ? LEVEL_MAX
                                                         : div_rsp.quotient[LEVEL_W-1:0];
    assign room  = target_reg ? (LEVEL_MAX - bright_reg) : bright_reg;
    assign delta = (qsat < room) ? qsat : room;

    assign light_on = cfg.active_high ? target_reg : ~target_reg;

    // Output register is free when empty or being drained this cycle.
    assign out_free = !ovalid_reg || out_ch.ready;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        bright_next      = bright_reg;
        target_next      = target_reg;
        fade_next        = fade_reg;
        pending_next     = pending_reg;
        last_next        = last_reg;
        now_next         = now_reg;
        wrote_next       = wrote_reg;
        ovalid_next      = ovalid_reg && !out_ch.ready;
        res_next         = res_reg;
        div_req.start    = 1'b0;
        div_req.dividend = elapsed;
        div_req.divisor  = period;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wrote_next = 1'b0;
                    state_next = S_OUT;
                    case (in_ch.cmd)
                        CMD_TICK:
                        begin
                            if (fade_reg)
                            begin
                                if (pending_reg)
                                begin
                                    // jump to the starting end; elapsed is zero, no step
                                    pending_next = 1'b0;
                                    bright_next  = target_reg ? LEVEL_MIN : LEVEL_MAX;
                                    last_next    = in_ch.now_ms;
                                end
                                else if (elapsed >= TIME_W'(period))
                                begin
                                    // a step is due: hand elapsed and the period to the divider
                                    div_req.start = 1'b1;
                                    now_next      = in_ch.now_ms;
                                    state_next    = S_DIV;
                                end
                            end
                        end
                        CMD_SET:
                        begin
                            if (pin != target_reg)
                            begin
                                pending_next = 1'b1;
                                fade_next    = 1'b1;
                            end
                            target_next = pin;
                        end
                        CMD_TOGGLE:
                        begin
                            target_next  = ~target_reg;
                            pending_next = 1'b1;
                            fade_next    = 1'b1;
                        end
                        default:
                        begin
                            // unknown command: report state unchanged
                            target_next = target_reg;
                        end
                    endcase
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    // advance toward the limit and end the fade there
                    last_next  = now_reg;
                    wrote_next = 1'b1;
                    if (target_reg)
                    begin
                        bright_next = bright_reg + delta;
                        if ((bright_reg + delta) == LEVEL_MAX)
                        begin
                            fade_next = 1'b0;
                        end
                    end
                    else
                    begin
                        bright_next = bright_reg - delta;
                        if ((bright_reg - delta) == LEVEL_MIN)
                        begin
                            fade_next = 1'b0;
                        end
                    end
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // load the result word once the output register can take it
                if (out_free)
                begin
                    res_next.level         = bright_reg;
                    res_next.level_written = wrote_reg;
                    res_next.light_is_on   = light_on;
                    res_next.fading        = fade_reg;
                    res_next.needs_power   = light_on || fade_reg;
                    ovalid_next            = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bright_reg  <= LEVEL_MIN;
            target_reg  <= 1'b0;
            fade_reg    <= 1'b0;
            pending_reg <= 1'b0;
            last_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bright_reg  <= bright_next;
            target_reg  <= target_next;
            fade_reg    <= fade_next;
            pending_reg <= pending_next;
            last_reg    <= last_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        wrote_reg <= wrote_next;
        res_reg   <= res_next;
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.level         = res_reg.level;
    assign out_ch.level_written = res_reg.level_written;
    assign out_ch.light_is_on   = res_reg.light_is_on;
    assign out_ch.fading        = res_reg.fading;
    assign out_ch.needs_power   = res_reg.needs_power;

endmodule
`default_nettype wire

>>> sv/plfc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plfc_cfg
// APB register file holding step period and output polarity.
// ----------------------------------------------------------------------------
module plfc_cfg
    import plfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_STEP_MS:     cfg_next.step_ms     = pwdata[STEP_W-1:0];
                REG_ACTIVE_HIGH: cfg_next.active_high = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_STEP_MS:     prdata = APB_DATA_W'(cfg_reg.step_ms);
            REG_ACTIVE_HIGH: prdata = APB_DATA_W'(cfg_reg.active_high);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ms     <= STEP_MS_RESET;
            cfg_reg.active_high <= ACTIVE_HIGH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> sv/plfc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plfc_div
// Restoring divider, one quotient bit per cycle, 32-bit by 8-bit.
// ----------------------------------------------------------------------------
module plfc_div
    import plfc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  div_req_t  req,
    output div_rsp_t  rsp
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STEP_W-1:0] rem_reg,   rem_next;
    logic [TIME_W-1:0] quo_reg,   quo_next;
    logic [STEP_W-1:0] dvs_reg,   dvs_next;
    logic [STEP_W:0]   trial;
    logic              fits;

    // shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = req.dividend;
            dvs_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? STEP_W'(trial - {1'b0, dvs_reg}) : trial[STEP_W-1:0];
            quo_next   = {quo_reg[TIME_W-2:0], fits};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

>>> tb/pwm_light_fade_controller_test.sv
// ----------------------------------------------------------------------------
// pwm_light_fade_controller_test
// Self-checking bench for the PWM light fade controller. A driver feeds command
// words from a backlog, a predictor computes the status word each accepted
// command should produce, and a monitor compares every result word field by
// field. Step period and polarity change between phases over the APB port.
// ----------------------------------------------------------------------------
module pwm_light_fade_controller_test;
    import plfc_pkg::*;

    // cmd 3 has no meaning; the block must report state and change nothing
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // cycles without any accepted word before the run is declared hung
    localparam int WATCHDOG_LIMIT = 6000;
    // long receiver hold-off, applied twice in the run
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_FIRST  = 60;
    localparam int HOLD_AT_SECOND = 400;
    localparam int RANDOM_PER_PHASE = 120;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              on_request;
        logic [TIME_W-1:0] now_ms;
    } light_cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               level_written;
        logic               light_is_on;
        logic               fading;
        logic               needs_power;
    } light_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    plfc_in_if  in_ch ();
    plfc_out_if out_ch ();

    pwm_light_fade_controller dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the registers and the fade state
    // ------------------------------------------------------------------------
    logic [STEP_W-1:0]  cfg_step_ms;
    logic               cfg_active_high;
    logic [LEVEL_W-1:0] bright_lvl;
    logic               pin_high;
    logic               fade_active;
    logic               start_armed;
    logic [TIME_W-1:0]  stamp_ms;

    light_cmd_t    cmd_backlog[$];
    light_status_t predicted_status[$];

    int mismatches = 0;
    int words_checked = 0;
    int idle_cycles = 0;
    logic [TIME_W-1:0] wall_ms;

    // Compute the status word for one command and advance the fade state.
    function automatic light_status_t advance_fade(light_cmd_t c);
        light_status_t     s;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] steps;
        logic [LEVEL_W-1:0] move;
        logic              pin;
        logic              on;
        s = '0;
        case (c.cmd)
            CMD_TICK:
            begin
                if (fade_active)
                begin
                    // first tick after arming: jump to the starting end, no write
                    if (start_armed)
                    begin
                        start_armed = 1'b0;
                        bright_lvl  = pin_high ? LEVEL_MIN : LEVEL_MAX;
                        stamp_ms    = c.now_ms;
                    end
                    period  = (cfg_step_ms == '0) ? TIME_W'(1) : TIME_W'(cfg_step_ms);
                    elapsed = c.now_ms - stamp_ms;
                    if (elapsed >= period)
                    begin
                        stamp_ms = c.now_ms;
                        steps    = elapsed / period;
                        move     = (steps > TIME_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                                : steps[LEVEL_W-1:0];
                        if (pin_high)
                        begin
                            if (move >= LEVEL_MAX - bright_lvl)
                            begin
                                bright_lvl  = LEVEL_MAX;
                                fade_active = 1'b0;
                            end
                            else
                            begin
                                bright_lvl = bright_lvl + move;
                            end
                        end
                        else
                        begin
                            if (move >= bright_lvl)
                            begin
                                bright_lvl  = LEVEL_MIN;
                                fade_active = 1'b0;
                            end
                            else
                            begin
                                bright_lvl = bright_lvl - move;
                            end
                        end
                        s.level_written = 1'b1;
                    end
                end
            end
            CMD_SET:
            begin
                pin = cfg_active_high ? c.on_request : ~c.on_request;
                if (pin != pin_high)
                begin
                    start_armed = 1'b1;
                    fade_active = 1'b1;
                end
                pin_high = pin;
            end
            CMD_TOGGLE:
            begin
                pin_high    = ~pin_high;
                start_armed = 1'b1;
                fade_active = 1'b1;
            end
            default:
            begin
            end
        endcase
        on = cfg_active_high ? pin_high : ~pin_high;
        s.level       = bright_lvl;
        s.light_is_on = on;
        s.fading      = fade_active;
        s.needs_power = on | fade_active;
        return s;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("word %0d: %s is %0h, predicted %0h", words_checked, field, got, want);
        mismatches++;
    endtask

    // Gap length: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present backlog words, predict on every accept
    // ------------------------------------------------------------------------
    int tx_gap = 0;
    int tx_count = 0;
    bit tx_calm = 1'b0;

    always @(posedge clk)
    begin
        light_cmd_t nxt;
        bit         fire;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            fire = in_ch.valid && in_ch.ready;
            if (fire)
            begin
                predicted_status.push_back(advance_fade({in_ch.cmd, in_ch.on_request,
                                                         in_ch.now_ms}));
                tx_count++;
                // re-roll the idling mode now and then so calm stretches appear
                if (tx_count % 32 == 0)
                    tx_calm = ($urandom_range(0, 2) == 0);
                tx_gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
            end
            if (!in_ch.valid || fire)
            begin
                if (tx_gap == 0 && cmd_backlog.size() != 0)
                begin
                    nxt = cmd_backlog.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.cmd        <= nxt.cmd;
                    in_ch.on_request <= nxt.on_request;
                    in_ch.now_ms     <= nxt.now_ms;
                end
                else
                begin
                    if (tx_gap != 0)
                        tx_gap--;
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, calm stretches, and two long hold-offs that
    // let the block fill up and back-pressure the driver
    // ------------------------------------------------------------------------
    int rx_hold = 0;
    int rx_taken = 0;
    int rx_cycles = 0;
    bit rx_calm = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            rx_cycles++;
            if (rx_cycles % 64 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            if (out_ch.valid && out_ch.ready)
            begin
                rx_taken++;
                if (rx_taken == HOLD_AT_FIRST || rx_taken == HOLD_AT_SECOND)
                    rx_hold = HOLD_CYCLES;
            end
            if (rx_hold == 0 && !rx_calm && $urandom_range(0, 9) == 0)
                rx_hold = pick_gap();
            if (rx_hold != 0)
            begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result word against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        light_status_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (predicted_status.size() == 0)
            begin
                // result word with nothing predicted
                flag_mismatch("unexpected word", 32'd1, 32'd0);
            end
            else
            begin
                want = predicted_status.pop_front();
                if (out_ch.level !== want.level)
                    flag_mismatch("level", 32'(out_ch.level), 32'(want.level));
                if (out_ch.level_written !== want.level_written)
                    flag_mismatch("level_written", 32'(out_ch.level_written),
                                  32'(want.level_written));
                if (out_ch.light_is_on !== want.light_is_on)
                    flag_mismatch("light_is_on", 32'(out_ch.light_is_on),
                                  32'(want.light_is_on));
                if (out_ch.fading !== want.fading)
                    flag_mismatch("fading", 32'(out_ch.fading), 32'(want.fading));
                if (out_ch.needs_power !== want.needs_power)
                    flag_mismatch("needs_power", 32'(out_ch.needs_power),
                                  32'(want.needs_power));
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up when no word moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pwm_light_fade_controller regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic req,
                             input logic [TIME_W-1:0] now, inout int count);
        cmd_backlog.push_back({cmd, req, now});
        if (cmd != CMD_UNUSED)
            count++;
    endtask

    // Advance the wall clock: mostly a few step periods, sometimes a gap that
    // can saturate the quotient, now and then a jump that wraps.
    task automatic advance_clock();
        int step;
        int r;
        step = (cfg_step_ms == '0) ? 1 : int'(cfg_step_ms);
        r = $urandom_range(0, 99);
        if (r < 60)
            wall_ms = wall_ms + TIME_W'($urandom_range(0, 3 * step));
        else if (r < 85)
            wall_ms = wall_ms + TIME_W'(step * $urandom_range(1, 30)
                                        + $urandom_range(0, step - 1));
        else if (r < 95)
            wall_ms = wall_ms + TIME_W'(step * $urandom_range(200, 400));
        else
            wall_ms = wall_ms + $urandom();
    endtask

    // Mostly a set/toggle followed by a run of ticks that carries the fade
    // along; the rest is lone ticks, lone commands and unknown commands.
    task automatic random_fades(input int target);
        int count;
        int ticks;
        int r;
        count = 0;
        while (count < target)
        begin
            if ($urandom_range(0, 4) == 0)
                wall_ms = $urandom();
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                if ($urandom_range(0, 1) == 0)
                    queue_cmd(CMD_SET, 1'($urandom_range(0, 1)), $urandom(), count);
                else
                    queue_cmd(CMD_TOGGLE, 1'($urandom_range(0, 1)), $urandom(), count);
                ticks = $urandom_range(1, 40);
                repeat (ticks)
                begin
                    advance_clock();
                    queue_cmd(CMD_TICK, 1'($urandom_range(0, 1)), wall_ms, count);
                end
            end
            else if (r < 85)
            begin
                advance_clock();
                queue_cmd(CMD_TICK, 1'($urandom_range(0, 1)), wall_ms, count);
            end
            else if (r < 95)
            begin
                queue_cmd($urandom_range(0, 1) ? CMD_SET : CMD_TOGGLE,
                          1'($urandom_range(0, 1)), $urandom(), count);
            end
            else
            begin
                queue_cmd(CMD_UNUSED, 1'($urandom_range(0, 1)), $urandom(), count);
            end
        end
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers change only with nothing in flight; mirror them in the
    // predictor once the write edge has passed.
    task automatic set_config(input logic [STEP_W-1:0] step, input logic act_high);
        write_reg({REG_STEP_MS, 2'b00}, APB_DATA_W'(step));
        cfg_step_ms = step;
        write_reg({REG_ACTIVE_HIGH, 2'b00}, APB_DATA_W'(act_high));
        cfg_active_high = act_high;
    endtask

    // Check mid-cycle, after the driver and monitor have settled for the edge.
    task automatic drain();
        while (cmd_backlog.size() != 0 || in_ch.valid || predicted_status.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_TICK;
        in_ch.on_request = 1'b0;
        in_ch.now_ms     = '0;
        out_ch.ready     = 1'b0;

        cfg_step_ms     = STEP_MS_RESET;
        cfg_active_high = ACTIVE_HIGH_RESET;
        bright_lvl      = LEVEL_MIN;
        pin_high        = 1'b0;
        fade_active     = 1'b0;
        start_armed     = 1'b0;
        stamp_ms        = '0;
        wall_ms         = '0;
        n = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Phase 0: reset settings, directed corners first.
        queue_cmd(CMD_UNUSED, 1'b1, 32'hFFFF_FFFF, n);      // unknown command
        queue_cmd(CMD_TICK,   1'b0, 32'h0000_0000, n);      // tick with no fade
        queue_cmd(CMD_SET,    1'b0, 32'h0000_0000, n);      // set, no change
        queue_cmd(CMD_SET,    1'b1, 32'h1234_5678, n);      // arm fade up
        queue_cmd(CMD_TICK,   1'b0, 32'hFFFF_FFF0, n);      // fade start, no write
        queue_cmd(CMD_TICK,   1'b1, 32'h0000_0005, n);      // elapsed across wrap
        queue_cmd(CMD_TICK,   1'b0, 32'h0000_0006, n);      // less than a step
        queue_cmd(CMD_TICK,   1'b0, 32'h8000_0000, n);      // saturating gap, ends
        queue_cmd(CMD_TICK,   1'b0, 32'h8000_1000, n);      // idle again
        queue_cmd(CMD_TOGGLE, 1'b1, 32'h0000_0000, n);      // arm fade down
        queue_cmd(CMD_SET,    1'b0, 32'h0000_0000, n);      // same pin, stays armed
        queue_cmd(CMD_TICK,   1'b0, 32'd100, n);            // jump to full
        queue_cmd(CMD_TICK,   1'b0, 32'd103, n);            // one step down
        queue_cmd(CMD_SET,    1'b1, 32'hFFFF_FFFF, n);      // re-arm mid-fade
        queue_cmd(CMD_TICK,   1'b1, 32'h7FFF_FFFF, n);
        queue_cmd(CMD_TICK,   1'b1, 32'h8000_0383, n);      // 300 steps, saturate
        queue_cmd(CMD_UNUSED, 1'b0, 32'h0000_0000, n);
        queue_cmd(CMD_TOGGLE, 1'b0, 32'hFFFF_FFFF, n);
        queue_cmd(CMD_TICK,   1'b1, 32'h5555_5555, n);
        queue_cmd(CMD_TICK,   1'b0, 32'hAAAA_AAAA, n);      // large gap to zero
        random_fades(RANDOM_PER_PHASE - 20);
        drain();

        // Phase 1: zero step acts as one, active-low polarity.
        set_config(8'd0, 1'b0);
        queue_cmd(CMD_SET,  1'b1, 32'h0000_0000, n);
        queue_cmd(CMD_TICK, 1'b0, 32'h0000_1000, n);
        queue_cmd(CMD_TICK, 1'b0, 32'h0000_1001, n);
        queue_cmd(CMD_TICK, 1'b0, 32'h0000_1001, n);
        queue_cmd(CMD_SET,  1'b0, 32'h0000_0000, n);
        random_fades(RANDOM_PER_PHASE);
        drain();

        // Phase 2: slowest step, active high.
        set_config(8'd255, 1'b1);
        random_fades(RANDOM_PER_PHASE);
        drain();

        // Phase 3: fastest legal step, active low.
        set_config(8'd1, 1'b0);
        random_fades(RANDOM_PER_PHASE);
        drain();

        // Phase 4: random settings.
        set_config(STEP_W'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
        random_fades(RANDOM_PER_PHASE);
        drain();

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("pwm_light_fade_controller regression: pass");
        else
            $display("pwm_light_fade_controller regression: fail");
        $finish;
    end

endmodule
